// File: hdl/fpfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_pkg: shared types and codes of the fixed partition fit allocator
// Item and result layouts, command codes, fit modes, register indexes,
// the scan sequencer states and the command bus to the block cells.
// ----------------------------------------------------------------------------
package fpfa_pkg;

    localparam int KIND_W     = 2;
    localparam int SLOT_W     = 4;
    localparam int AMOUNT_W   = 16;
    localparam int CHOSEN_W   = 4;
    localparam int LEFT_W     = 16;
    localparam int TOTAL_W    = 20;
    localparam int SEL_W      = 6;   // covers the largest block table
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [LEFT_W-1:0]  LEFT_MAX  = '1;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

    // fit modes
    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;
    localparam logic [1:0] MODE_NEXT  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BLOCK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 2'd2;

    localparam logic [4:0] BLOCKS_IN_USE_RST = 5'd16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LAUNCH,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [SLOT_W-1:0]   slot;
        logic [AMOUNT_W-1:0] amount;
    } t_in_item;

    typedef struct packed {
        logic                granted;
        logic [CHOSEN_W-1:0] chosen_block;
        logic [LEFT_W-1:0]   leftover;
        logic [TOTAL_W-1:0]  internal_total;
        logic [TOTAL_W-1:0]  external_total;
    } t_out_item;

    // broadcast to every cell; load and mark never share a cycle
    typedef struct packed {
        logic                load_en;
        logic                restart;
        logic                mark_en;
        logic [SEL_W-1:0]    sel;
        logic [AMOUNT_W-1:0] data;
    } t_cell_cmd;

endpackage

// File: hdl/fixed_partition_fit_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator: fixed partition block allocator
// Table of block sizes with used marks; first, best, worst or next fit.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (i_in_valid / o_in_stall, i_in_data) takes one item: a
//   block size load, an allocate request or a restart. Output channel
//   (o_out_valid / i_out_stall, o_out_data) returns exactly one result per
//   item, in order. Registers are written through i_cfg_we / i_cfg_idx /
//   i_cfg_wdata while no item is in flight.
//   Each item is launched as a search packet that walks the chain of block
//   cells one cell per cycle; its pick is captured at the chain tail and
//   committed to the result register, and only then is the next item taken.
//   Loads and restarts take the same pass to refresh the free total.
//   A finished result waits in the output register while the receiver
//   stalls; the next item is accepted meanwhile, and its result is held at
//   the chain tail until the register frees.
//   Reset clears the used marks, the roving pointer and the fragmentation
//   total and loads register defaults; block sizes hold no value until
//   loaded.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  fpfa_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output fpfa_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [fpfa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fpfa_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import fpfa_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int SUM_W = SIZE_BITS + IDX_W;

    t_cell_cmd             cmd;
    logic [1:0]            mode;
    logic [CNT_W-1:0]      cnt;
    logic [IDX_W-1:0]      start;
    logic [AMOUNT_W-1:0]   req;
    logic                  launch;

    logic [MAX_BLOCKS:0]   pk_vld;
    logic [MAX_BLOCKS:0]   pk_fa;
    logic [MAX_BLOCKS:0]   pk_fb;
    logic [IDX_W-1:0]      pk_a_idx  [MAX_BLOCKS+1];
    logic [SIZE_BITS-1:0]  pk_a_size [MAX_BLOCKS+1];
    logic [IDX_W-1:0]      pk_b_idx  [MAX_BLOCKS+1];
    logic [SIZE_BITS-1:0]  pk_b_size [MAX_BLOCKS+1];
    logic [SUM_W-1:0]      pk_sum    [MAX_BLOCKS+1];

    // empty packet enters the head of the chain
    assign pk_vld[0]    = launch;
    assign pk_fa[0]     = 1'b0;
    assign pk_fb[0]     = 1'b0;
    assign pk_a_idx[0]  = '0;
    assign pk_a_size[0] = '0;
    assign pk_b_idx[0]  = '0;
    assign pk_b_size[0] = '0;
    assign pk_sum[0]    = '0;

    fpfa_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cmd       (cmd),
        .o_mode      (mode),
        .o_cnt       (cnt),
        .o_start     (start),
        .o_req       (req),
        .o_launch    (launch),
        .i_t_vld     (pk_vld[MAX_BLOCKS]),
        .i_t_fa      (pk_fa[MAX_BLOCKS]),
        .i_t_a_idx   (pk_a_idx[MAX_BLOCKS]),
        .i_t_a_size  (pk_a_size[MAX_BLOCKS]),
        .i_t_fb      (pk_fb[MAX_BLOCKS]),
        .i_t_b_idx   (pk_b_idx[MAX_BLOCKS]),
        .i_t_b_size  (pk_b_size[MAX_BLOCKS]),
        .i_t_sum     (pk_sum[MAX_BLOCKS])
    );

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        fpfa_cell #(
            .MAX_BLOCKS (MAX_BLOCKS),
            .SIZE_BITS  (SIZE_BITS),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (cmd),
            .i_mode   (mode),
            .i_cnt    (cnt),
            .i_start  (start),
            .i_req    (req),
            .i_vld    (pk_vld[g]),
            .i_fa     (pk_fa[g]),
            .i_a_idx  (pk_a_idx[g]),
            .i_a_size (pk_a_size[g]),
            .i_fb     (pk_fb[g]),
            .i_b_idx  (pk_b_idx[g]),
            .i_b_size (pk_b_size[g]),
            .i_sum    (pk_sum[g]),
            .o_vld    (pk_vld[g+1]),
            .o_fa     (pk_fa[g+1]),
            .o_a_idx  (pk_a_idx[g+1]),
            .o_a_size (pk_a_size[g+1]),
            .o_fb     (pk_fb[g+1]),
            .o_b_idx  (pk_b_idx[g+1]),
            .o_b_size (pk_b_size[g+1]),
            .o_sum    (pk_sum[g+1])
        );
    end

    // only one search packet in the chain at a time
    a_one_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(pk_vld) <= 1)
        else $error("more than one search packet in the cell chain");

    // input is held off while a packet is in flight
    a_stall_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pk_vld != '0) |-> o_in_stall)
        else $error("input accepted while a search was running");

    // a launched packet passes every cell and leaves the tail of the chain
    a_launch_to_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        launch |=> ##(MAX_BLOCKS - 1) pk_vld[MAX_BLOCKS])
        else $error("search packet lost in the cell chain");

    // a refused or non-allocate result reports no block and no leftover
    a_no_grant_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.granted) |->
            (o_out_data.chosen_block == '0 && o_out_data.leftover == '0))
        else $error("result without grant carries a block or leftover");

endmodule

// File: hdl/fpfa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_cell: one block of the partition table
// Holds one block size and its used mark, and updates the search packet
// that passes through on its way down the chain, one cell per cycle.
// ----------------------------------------------------------------------------
module fpfa_cell #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 16,
    parameter int CELL_IDX   = 0
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  fpfa_pkg::t_cell_cmd                    i_cmd,
    input  logic [1:0]                             i_mode,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0]        i_cnt,
    input  logic [$clog2(MAX_BLOCKS)-1:0]          i_start,
    input  logic [fpfa_pkg::AMOUNT_W-1:0]          i_req,
    input  logic                                   i_vld,
    input  logic                                   i_fa,
    input  logic [$clog2(MAX_BLOCKS)-1:0]          i_a_idx,
    input  logic [SIZE_BITS-1:0]                   i_a_size,
    input  logic                                   i_fb,
    input  logic [$clog2(MAX_BLOCKS)-1:0]          i_b_idx,
    input  logic [SIZE_BITS-1:0]                   i_b_size,
    input  logic [SIZE_BITS+$clog2(MAX_BLOCKS)-1:0] i_sum,
    output logic                                   o_vld,
    output logic                                   o_fa,
    output logic [$clog2(MAX_BLOCKS)-1:0]          o_a_idx,
    output logic [SIZE_BITS-1:0]                   o_a_size,
    output logic                                   o_fb,
    output logic [$clog2(MAX_BLOCKS)-1:0]          o_b_idx,
    output logic [SIZE_BITS-1:0]                   o_b_size,
    output logic [SIZE_BITS+$clog2(MAX_BLOCKS)-1:0] o_sum
);
    import fpfa_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int SUM_W = SIZE_BITS + IDX_W;
    localparam int CMP_W = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(CELL_IDX);
    localparam logic [SEL_W-1:0] MY_SEL = SEL_W'(CELL_IDX);

    logic [SIZE_BITS-1:0] r_size;
    logic                 r_used;
    logic [CMP_W-1:0]     load_w;
    logic                 active;
    logic                 fit;
    logic                 take_a;
    logic                 take_b;

    logic                 r_vld;
    logic                 r_fa;
    logic [IDX_W-1:0]     r_a_idx;
    logic [SIZE_BITS-1:0] r_a_size;
    logic                 r_fb;
    logic [IDX_W-1:0]     r_b_idx;
    logic [SIZE_BITS-1:0] r_b_size;
    logic [SUM_W-1:0]     r_sum;
    logic [SUM_W-1:0]     n_sum;

    always_comb begin
        load_w = CMP_W'(i_cmd.data);
        active = (MY_POS < i_cnt);
        fit    = active && !r_used && (CMP_W'(r_size) >= CMP_W'(i_req));
        n_sum  = i_sum + ((active && !r_used) ? SUM_W'(r_size) : '0);
    end

    // same request for every cell, so comparing sizes orders the leftovers
    always_comb begin
        take_a = 1'b0;
        case (i_mode)
            MODE_FIRST: take_a = fit && !i_fa;
            MODE_BEST:  take_a = fit && (!i_fa || (r_size < i_a_size));
            MODE_WORST: take_a = fit && (!i_fa || (r_size > i_a_size));
            MODE_NEXT:  take_a = fit && !i_fa && (MY_IDX >= i_start);
        endcase
        take_b = (i_mode == MODE_NEXT) && fit && !i_fb && (MY_IDX < i_start);
    end

    // block table entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_en && (i_cmd.sel == MY_SEL)) begin
            r_size <= load_w[SIZE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_cmd.restart) begin
            r_used <= 1'b0;
        end else if (i_cmd.mark_en && (i_cmd.sel == MY_SEL)) begin
            r_used <= 1'b1;
        end
    end

    // packet stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fa     <= i_fa || take_a;
        r_a_idx  <= take_a ? MY_IDX : i_a_idx;
        r_a_size <= take_a ? r_size : i_a_size;
        r_fb     <= i_fb || take_b;
        r_b_idx  <= take_b ? MY_IDX : i_b_idx;
        r_b_size <= take_b ? r_size : i_b_size;
        r_sum    <= n_sum;
    end

    assign o_vld    = r_vld;
    assign o_fa     = r_fa;
    assign o_a_idx  = r_a_idx;
    assign o_a_size = r_a_size;
    assign o_fb     = r_fb;
    assign o_b_idx  = r_b_idx;
    assign o_b_size = r_b_size;
    assign o_sum    = r_sum;

endmodule

// File: hdl/fpfa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_ctrl: item sequencer of the fixed partition fit allocator
// Takes items and register writes, launches the search packet into the
// cell chain, settles the pick at the tail, commits it and drives results.
// ----------------------------------------------------------------------------
module fpfa_ctrl #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  fpfa_pkg::t_in_item                     i_in_data,
    output logic                                   o_in_stall,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output fpfa_pkg::t_out_item                    o_out_data,
    input  logic                                   i_cfg_we,
    input  logic [fpfa_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [fpfa_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    output fpfa_pkg::t_cell_cmd                    o_cmd,
    output logic [1:0]                             o_mode,
    output logic [$clog2(MAX_BLOCKS+1)-1:0]        o_cnt,
    output logic [$clog2(MAX_BLOCKS)-1:0]          o_start,
    output logic [fpfa_pkg::AMOUNT_W-1:0]          o_req,
    output logic                                   o_launch,
    input  logic                                   i_t_vld,
    input  logic                                   i_t_fa,
    input  logic [$clog2(MAX_BLOCKS)-1:0]          i_t_a_idx,
    input  logic [SIZE_BITS-1:0]                   i_t_a_size,
    input  logic                                   i_t_fb,
    input  logic [$clog2(MAX_BLOCKS)-1:0]          i_t_b_idx,
    input  logic [SIZE_BITS-1:0]                   i_t_b_size,
    input  logic [SIZE_BITS+$clog2(MAX_BLOCKS)-1:0] i_t_sum
);
    import fpfa_pkg::*;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int SUM_W  = SIZE_BITS + IDX_W;
    localparam int CMP_W  = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;
    localparam int ROV_W  = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int BU_W   = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
    localparam int RC_W   = (ROV_W > CNT_W) ? ROV_W : CNT_W;
    localparam int FRAG_W = ((CMP_W > TOTAL_W) ? CMP_W : TOTAL_W) + 1;
    localparam int EXT_W  = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;

    t_state r_state;
    t_state n_state;

    logic [1:0]            r_fit_mode;
    logic [SLOT_W-1:0]     r_start_block;
    logic [4:0]            r_blocks_in_use;
    logic [ROV_W-1:0]      r_rover;
    logic [TOTAL_W-1:0]    r_frag;

    logic [KIND_W-1:0]     r_kind;
    logic [AMOUNT_W-1:0]   r_amount;

    logic                  r_fa;
    logic [IDX_W-1:0]      r_a_idx;
    logic [SIZE_BITS-1:0]  r_a_size;
    logic                  r_fb;
    logic [IDX_W-1:0]      r_b_idx;
    logic [SIZE_BITS-1:0]  r_b_size;
    logic [SUM_W-1:0]      r_sum;

    logic                  r_o_valid;
    t_out_item             r_o_data;
    t_out_item             n_o_data;

    logic                  accept;
    logic                  out_free;
    logic                  commit;
    logic                  capture;
    logic                  busy;
    logic [CNT_W-1:0]      cnt;
    logic [IDX_W-1:0]      start;

    logic                  grant;
    logic [IDX_W-1:0]      pick_idx;
    logic [SIZE_BITS-1:0]  pick_size;
    logic [CMP_W-1:0]      diff;
    logic [LEFT_W-1:0]     left;
    logic [FRAG_W-1:0]     frag_sum;
    logic [TOTAL_W-1:0]    n_frag;
    logic [SUM_W-1:0]      ext_sum;
    logic [TOTAL_W-1:0]    ext;
    logic [CNT_W-1:0]      pick_inc;
    logic [ROV_W-1:0]      n_rover;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode      <= MODE_FIRST;
            r_start_block   <= '0;
            r_blocks_in_use <= BLOCKS_IN_USE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIT_MODE:      r_fit_mode      <= i_cfg_wdata[1:0];
                CFG_START_BLOCK:   r_start_block   <= i_cfg_wdata[SLOT_W-1:0];
                CFG_BLOCKS_IN_USE: r_blocks_in_use <= i_cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (BU_W'(r_blocks_in_use) > BU_W'(MAX_BLOCKS)) begin
            cnt = CNT_W'(MAX_BLOCKS);
        end else begin
            cnt = CNT_W'(r_blocks_in_use);
        end
        // rover beyond the blocks in use restarts the circular search at 0
        if (RC_W'(r_rover) < RC_W'(cnt)) begin
            start = IDX_W'(r_rover);
        end else begin
            start = '0;
        end
    end

    // ---------------- state machine ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_LAUNCH;
            S_LAUNCH: n_state = S_SCAN;
            S_SCAN:   if (i_t_vld) n_state = S_FINISH;
            S_FINISH: if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        out_free = !r_o_valid || !i_out_stall;
        busy     = 1'b1;
        o_launch = 1'b0;
        capture  = 1'b0;
        commit   = 1'b0;
        unique case (r_state)
            S_IDLE:   busy = 1'b0;
            S_LAUNCH: o_launch = 1'b1;
            S_SCAN:   capture = i_t_vld;
            S_FINISH: commit = out_free;
            default:  busy = 1'b1;
        endcase
        accept = i_in_valid && !busy;
    end

    // ---------------- item and tail capture ----------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= i_in_data.kind;
            r_amount <= i_in_data.amount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_fa     <= i_t_fa;
            r_a_idx  <= i_t_a_idx;
            r_a_size <= i_t_a_size;
            r_fb     <= i_t_fb;
            r_b_idx  <= i_t_b_idx;
            r_b_size <= i_t_b_size;
            r_sum    <= i_t_sum;
        end
    end

    // ---------------- settle the pick ----------------
    always_comb begin
        // wrapped part of the circular search only counts when the upper part missed
        grant     = (r_kind == KIND_ALLOC) && (r_fa || r_fb);
        pick_idx  = r_fa ? r_a_idx : r_b_idx;
        pick_size = r_fa ? r_a_size : r_b_size;
        diff      = CMP_W'(pick_size) - CMP_W'(r_amount);
        if (diff > CMP_W'(LEFT_MAX)) begin
            left = LEFT_MAX;
        end else begin
            left = LEFT_W'(diff);
        end
        frag_sum = FRAG_W'(r_frag) + FRAG_W'(diff);
        if (frag_sum > FRAG_W'(TOTAL_MAX)) begin
            n_frag = TOTAL_MAX;
        end else begin
            n_frag = TOTAL_W'(frag_sum);
        end
        ext_sum = r_sum - (grant ? SUM_W'(pick_size) : '0);
        if (EXT_W'(ext_sum) > EXT_W'(TOTAL_MAX)) begin
            ext = TOTAL_MAX;
        end else begin
            ext = TOTAL_W'(ext_sum);
        end
        pick_inc = CNT_W'(pick_idx) + CNT_W'(1);
        if (pick_inc >= cnt) begin
            n_rover = '0;
        end else begin
            n_rover = ROV_W'(pick_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frag  <= '0;
            r_rover <= '0;
        end else if (accept && (i_in_data.kind == KIND_RESTART)) begin
            r_frag  <= '0;
            r_rover <= ROV_W'(r_start_block);
        end else if (commit && grant) begin
            r_frag <= n_frag;
            if (r_fit_mode == MODE_NEXT) begin
                r_rover <= n_rover;
            end
        end
    end

    // ---------------- cell commands ----------------
    always_comb begin
        o_cmd = '0;
        if (accept) begin
            o_cmd.load_en = (i_in_data.kind == KIND_LOAD);
            o_cmd.restart = (i_in_data.kind == KIND_RESTART);
            o_cmd.sel     = SEL_W'(i_in_data.slot);
            o_cmd.data    = i_in_data.amount;
        end else if (commit && grant) begin
            o_cmd.mark_en = 1'b1;
            o_cmd.sel     = SEL_W'(pick_idx);
        end
    end

    // ---------------- result register ----------------
    always_comb begin
        n_o_data                = '0;
        n_o_data.granted        = grant;
        n_o_data.chosen_block   = grant ? CHOSEN_W'(pick_idx) : '0;
        n_o_data.leftover       = grant ? left : '0;
        n_o_data.internal_total = grant ? n_frag : r_frag;
        n_o_data.external_total = ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (commit) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_o_data <= n_o_data;
        end
    end

    assign o_in_stall  = busy;
    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;
    assign o_mode      = r_fit_mode;
    assign o_cnt       = cnt;
    assign o_start     = start;
    assign o_req       = r_amount;

endmodule
